// ===== rtl/core/mchw_pkg.sv =====
// shared types and constants of the heartbeat watchdog
package mchw_pkg;

  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned MaskW = 16;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_HEARTBEAT  = 3'd2,
    OP_REARM      = 3'd3,
    OP_RST_ATT    = 3'd4,
    OP_CHECK      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_DEF_TIMEOUT = 2'd0,
    CFG_DEF_AUTO    = 2'd1,
    CFG_DEF_MAX     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_CHECK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  svc_id;
    logic [31:0] time_ms;
    logic        use_defaults;
    logic [31:0] tmo_ms;
    logic        crit;
    logic        auto_rst;
    logic [7:0]  max_attempts;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] restart_mask;
    logic [15:0] timeout_mask;
    logic        safe_on;
    logic [31:0] timeout_cnt;
    logic [31:0] restart_cnt;
    logic [31:0] crit_cnt;
  } out_t;

  // one table entry as stored in memory (active bit kept in flops)
  typedef struct packed {
    logic [7:0]  service;
    logic [31:0] timeout;
    logic        critical;
    logic        autorestart;
    logic [7:0]  budget;
    logic [31:0] last_beat;
    logic [7:0]  attempts;
    logic        timed_out;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] waddr;
    entry_t           wdata;
    logic [SlotW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/mchw_if.sv =====
// valid/ready channel interfaces for payload and configuration
interface mchw_in_if (input logic clk_i);
  logic         valid;
  logic         ready;
  mchw_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mchw_out_if (input logic clk_i);
  logic           valid;
  logic           ready;
  mchw_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mchw_cfg_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/mchw_table.sv =====
// slot table memory with one write and one registered read port
module mchw_table (
  input  logic                clk_i,
  input  mchw_pkg::mem_req_t  req_i,
  output mchw_pkg::entry_t    rdata_o
);
  mchw_pkg::entry_t mem [mchw_pkg::Slots];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end
endmodule

// ===== rtl/core/mchw_ctrl.sv =====
// sequencer: walks the table for lookups and checks, updates entries
module mchw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  mchw_in_if.sink             in_ch,
  mchw_out_if.source          out_ch,
  mchw_cfg_if.sink            cfg_ch,
  output mchw_pkg::mem_req_t  req_o,
  input  mchw_pkg::entry_t    rdata_i
);
  localparam int unsigned SW = mchw_pkg::SlotW;

  mchw_pkg::state_e state_q, state_d;
  mchw_pkg::in_t    item_q;
  logic [mchw_pkg::Slots-1:0] active_q, active_d;
  logic [SW:0]      idx_q, idx_d;     // slot whose read is in flight
  logic             rd_ok_q, rd_ok_d; // read data valid for slot idx_q-1
  logic             hit_q, hit_d, free_ok_q, free_ok_d;
  logic [SW-1:0]    hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [31:0]      def_to_q;
  logic             def_auto_q;
  logic [7:0]       def_max_q;
  logic             safe_q, safe_d;
  logic [31:0]      tcnt_q, tcnt_d, rcnt_q, rcnt_d, ccnt_q, ccnt_d;
  logic [15:0]      rmask_q, rmask_d, tmask_q, tmask_d;
  logic [1:0]       status_q, status_d;
  logic [SW-1:0]    cur;
  logic [31:0]      elapsed;
  mchw_pkg::entry_t upd;
  logic             upd_we;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_q == mchw_pkg::S_IDLE);
  assign out_ch.valid = (state_q == mchw_pkg::S_OUT);
  assign out_ch.data  = '{status: status_q, restart_mask: rmask_q, timeout_mask: tmask_q,
                          safe_on: safe_q, timeout_cnt: tcnt_q,
                          restart_cnt: rcnt_q, crit_cnt: ccnt_q};

  assign cur     = idx_q[SW-1:0] - SW'(1);
  assign elapsed = item_q.time_ms - rdata_i.last_beat;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mchw_pkg::S_IDLE:
        if (in_ch.valid) begin
          state_d = (in_ch.data.op == mchw_pkg::OP_CHECK) ? mchw_pkg::S_CHECK
                  : (in_ch.data.op > mchw_pkg::OP_CHECK) ? mchw_pkg::S_OUT
                  : mchw_pkg::S_SCAN;
        end
      mchw_pkg::S_SCAN:
        if (rd_ok_q && idx_q == (SW+1)'(mchw_pkg::Slots)) state_d = mchw_pkg::S_APPLY;
      mchw_pkg::S_APPLY: state_d = mchw_pkg::S_OUT;
      mchw_pkg::S_CHECK:
        if (rd_ok_q && idx_q == (SW+1)'(mchw_pkg::Slots)) state_d = mchw_pkg::S_OUT;
      mchw_pkg::S_OUT:
        if (out_ch.ready) state_d = mchw_pkg::S_IDLE;
      default: state_d = mchw_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    active_d = active_q; idx_d = idx_q; rd_ok_d = rd_ok_q;
    hit_d = hit_q; hit_idx_d = hit_idx_q; free_ok_d = free_ok_q; free_idx_d = free_idx_q;
    safe_d = safe_q; tcnt_d = tcnt_q; rcnt_d = rcnt_q; ccnt_d = ccnt_q;
    rmask_d = rmask_q; tmask_d = tmask_q; status_d = status_q;
    upd = rdata_i; upd_we = 1'b0;
    req_o.raddr = idx_q[SW-1:0];
    req_o.we = 1'b0; req_o.waddr = cur; req_o.wdata = upd;
    unique case (state_q)
      mchw_pkg::S_IDLE: begin
        idx_d = '0; rd_ok_d = 1'b0; hit_d = 1'b0; free_ok_d = 1'b0;
        rmask_d = '0; tmask_d = '0; status_d = mchw_pkg::ST_OK;
      end
      mchw_pkg::S_SCAN: begin
        if (rd_ok_q) begin
          if (active_q[cur] && rdata_i.service == item_q.svc_id && !hit_q) begin
            hit_d = 1'b1; hit_idx_d = cur;
          end
          if (!active_q[cur] && !free_ok_q) begin
            free_ok_d = 1'b1; free_idx_d = cur;
          end
        end
        if (idx_q != (SW+1)'(mchw_pkg::Slots)) begin
          idx_d = idx_q + 1'b1; rd_ok_d = 1'b1;
        end
        // point the read at the hit slot for the apply cycle
        req_o.raddr = (idx_q == (SW+1)'(mchw_pkg::Slots)) ? hit_idx_d : idx_q[SW-1:0];
      end
      mchw_pkg::S_APPLY: begin
        req_o.waddr = hit_idx_q;
        if (item_q.op == mchw_pkg::OP_REGISTER) begin
          if (hit_q) status_d = mchw_pkg::ST_DUPLICATE;
          else if (!free_ok_q) status_d = mchw_pkg::ST_FULL;
          else begin
            active_d[free_idx_q] = 1'b1;
            req_o.we = 1'b1; req_o.waddr = free_idx_q;
            upd.service = item_q.svc_id; upd.last_beat = item_q.time_ms;
            upd.attempts = '0; upd.timed_out = 1'b0;
            if (item_q.use_defaults) begin
              upd.timeout = def_to_q; upd.autorestart = def_auto_q;
              upd.budget = def_max_q; upd.critical = 1'b0;
            end else begin
              upd.timeout = item_q.tmo_ms; upd.critical = item_q.crit;
              upd.autorestart = item_q.auto_rst; upd.budget = item_q.max_attempts;
            end
          end
        end else if (!hit_q) begin
          if (item_q.op != mchw_pkg::OP_HEARTBEAT) status_d = mchw_pkg::ST_NOT_FOUND;
        end else begin
          case (item_q.op)
            mchw_pkg::OP_UNREGISTER: active_d[hit_idx_q] = 1'b0;
            mchw_pkg::OP_HEARTBEAT, mchw_pkg::OP_REARM: begin
              upd.last_beat = item_q.time_ms; req_o.we = 1'b1;
            end
            default: begin
              upd.attempts = '0; req_o.we = 1'b1;
            end
          endcase
        end
        req_o.wdata = upd;
      end
      mchw_pkg::S_CHECK: begin
        if (idx_q != (SW+1)'(mchw_pkg::Slots)) begin
          idx_d = idx_q + 1'b1; rd_ok_d = 1'b1;
        end
        if (rd_ok_q && active_q[cur]) begin
          if (elapsed > rdata_i.timeout) begin
            if (!rdata_i.timed_out) begin
              upd_we = 1'b1; upd.timed_out = 1'b1;
              tcnt_d = tcnt_q + 32'd1;
              tmask_d[cur] = 1'b1;
              if (rdata_i.critical) begin
                if (!safe_q) begin
                  safe_d = 1'b1; ccnt_d = ccnt_q + 32'd1;
                end
              end else if (rdata_i.autorestart &&
                           (rdata_i.budget == 8'd0 || rdata_i.attempts < rdata_i.budget)) begin
                upd.attempts = rdata_i.attempts + 8'd1;
                rcnt_d = rcnt_q + 32'd1;
                rmask_d[cur] = 1'b1;
                upd.last_beat = item_q.time_ms;
                upd.timed_out = 1'b0;
              end
            end
          end else if (rdata_i.timed_out) begin
            upd_we = 1'b1; upd.timed_out = 1'b0; upd.attempts = '0;
          end
        end
        req_o.we = upd_we; req_o.wdata = upd;
      end
      mchw_pkg::S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mchw_pkg::S_IDLE; active_q <= '0; idx_q <= '0; rd_ok_q <= 1'b0;
      hit_q <= 1'b0; free_ok_q <= 1'b0; safe_q <= 1'b0;
      tcnt_q <= '0; rcnt_q <= '0; ccnt_q <= '0;
      def_to_q <= 32'd5000; def_auto_q <= 1'b1; def_max_q <= 8'd3;
    end else begin
      state_q <= state_d; active_q <= active_d; idx_q <= idx_d; rd_ok_q <= rd_ok_d;
      hit_q <= hit_d; free_ok_q <= free_ok_d; safe_q <= safe_d;
      tcnt_q <= tcnt_d; rcnt_q <= rcnt_d; ccnt_q <= ccnt_d;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          mchw_pkg::CFG_DEF_TIMEOUT: def_to_q <= cfg_ch.wdata;
          mchw_pkg::CFG_DEF_AUTO:    def_auto_q <= cfg_ch.wdata[0];
          mchw_pkg::CFG_DEF_MAX:     def_max_q <= cfg_ch.wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) item_q <= in_ch.data;
    hit_idx_q <= hit_idx_d; free_idx_q <= free_idx_d;
    rmask_q <= rmask_d; tmask_q <= tmask_d; status_q <= status_d;
  end
endmodule

// ===== rtl/core/multi_channel_heartbeat_watchdog.sv =====
// top level of the multi-channel heartbeat watchdog
// Usage:
//   in_ch carries one operation per beat (register, unregister, heartbeat,
//   rearm, reset attempts, check); out_ch returns exactly one result beat
//   per operation, holding status, the check masks, safe mode and counters.
//   cfg_ch writes the default timeout, auto-restart and budget registers and
//   is always ready; write it only while the block is idle (unenforced).
// Timing:
//   the slot table sits in a single-port-read memory read one slot per cycle.
//   Lookup ops walk the table through the memory's read port and then apply
//   their update; a check walks the table; unknown ops go straight to the
//   result. One operation is in flight at a time; ready rises again the
//   cycle after the result beat is taken.
// Reset:
//   all slots inactive, counters and safe mode cleared, defaults 5000/1/3.
//   No clearing pass: the contents of inactive entries are never used.
// Stall:
//   a result waits in its output register until out_ch.ready; no new
//   operation is accepted meanwhile.
module multi_channel_heartbeat_watchdog (
  input  logic        clk_i,
  input  logic        rst_ni,
  mchw_in_if.sink     in_ch,
  mchw_out_if.source  out_ch,
  mchw_cfg_if.sink    cfg_ch
);
  mchw_pkg::mem_req_t req;
  mchw_pkg::entry_t   rdata;

  mchw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_ch, .out_ch, .cfg_ch, .req_o(req), .rdata_i(rdata)
  );

  mchw_table u_table (.clk_i, .req_i(req), .rdata_o(rdata));
endmodule

// ===== rtl/core/mchw_checker.sv =====
// port-level assertions for the heartbeat watchdog
module mchw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input mchw_pkg::out_t out_data_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while result pending");
  a_safe_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_data_i.safe_on |=> !out_valid_i ||
      out_data_i.safe_on)
    else $error("safe mode cleared");
  a_rmask_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.restart_mask & ~out_data_i.timeout_mask) == 16'd0)
    else $error("restart without timeout");
endmodule

bind multi_channel_heartbeat_watchdog mchw_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_i(out_ch.data)
);
